// ===== src/ndi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndi_pkg
// Shared types, codes and fixed-point helpers of the Newmark DOF integrator.
// ----------------------------------------------------------------------------
package ndi_pkg;

   localparam int NUM_DOFS = 1024;
   localparam int IDX_W    = 10;
   localparam int ADDR_W   = $clog2(NUM_DOFS);

   typedef logic signed [31:0] fix_type;

   localparam fix_type ONE_Q = 32'sd65536;
   localparam fix_type TWO_Q = 32'sd131072;
   localparam fix_type FIX_MAX = 32'sh7FFFFFFF;
   localparam fix_type FIX_MIN = 32'sh80000000;

   // reciprocal of three, scaled by 2^34 and rounded down
   localparam logic [32:0] DIV3_MAGIC = 33'd5726623061;

   // request codes
   localparam logic [2:0] REQ_LOAD   = 3'd0;
   localparam logic [2:0] REQ_STEP   = 3'd1;
   localparam logic [2:0] REQ_UPDATE = 3'd2;
   localparam logic [2:0] REQ_REVERT = 3'd3;
   localparam logic [2:0] REQ_COMMIT = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_VEL_GAIN       = 3'd0;
   localparam logic [2:0] CSR_ACC_GAIN       = 3'd1;
   localparam logic [2:0] CSR_PRED_VEL_KEEP  = 3'd2;
   localparam logic [2:0] CSR_PRED_VEL_ACC   = 3'd3;
   localparam logic [2:0] CSR_PRED_ACC_KEEP  = 3'd4;
   localparam logic [2:0] CSR_PRED_ACC_VEL   = 3'd5;
   localparam logic [2:0] CSR_POLY_ORDER     = 3'd6;
   localparam logic [2:0] CSR_INV_MAX_ITER   = 3'd7;

   // extrapolation orders
   localparam logic [1:0] POLY_NONE  = 2'd0;
   localparam logic [1:0] POLY_LIN   = 2'd1;
   localparam logic [1:0] POLY_QUAD  = 2'd2;
   localparam logic [1:0] POLY_CUBIC = 2'd3;

   // per-DOF state row
   typedef struct packed {
      fix_type oo;   // oldest displacement
      fix_type od;   // older displacement
      fix_type sa;   // step acceleration
      fix_type sv;   // step velocity
      fix_type sd;   // step displacement
      fix_type ta;   // trial acceleration
      fix_type tv;   // trial velocity
      fix_type td;   // trial displacement
   } row_type;

   localparam int ROW_W = $bits(row_type);

   // everything one item carries down the pipeline
   typedef struct packed {
      logic [2:0]       typ;
      logic [IDX_W-1:0] idx;
      fix_type          du;
      logic [15:0]      iter;
      fix_type          ld;
      fix_type          lv;
      fix_type          la;
      row_type          row;
      fix_type          x;
      fix_type          xm1;
      fix_type          xp1;
      fix_type          xp2;
      fix_type          unew;
      fix_type          pa;
      fix_type          pb;
      fix_type          pc;
      fix_type          o1a;
      fix_type          o1b;
      fix_type          sva;
      fix_type          svb;
      fix_type          saa;
      fix_type          sab;
      fix_type          nv;
      fix_type          na;
      fix_type          qa;
      fix_type          qb;
      fix_type          qc;
      fix_type          qd;
      fix_type          w2a;
      fix_type          w2c;
      logic [33:0]      ua;
      logic [33:0]      ud;
      logic [33:0]      q0a;
      logic [33:0]      q0d;
      fix_type          w3a;
      fix_type          w3b;
      fix_type          w3c;
      fix_type          w3d;
      fix_type          t2a;
      fix_type          t2b;
      fix_type          t2c;
      fix_type          t3a;
      fix_type          t3b;
      fix_type          t3c;
      fix_type          t3d;
      fix_type          s;
      fix_type          vgs;
      fix_type          ags;
   } pipe_type;

   function automatic fix_type sat32(input logic signed [63:0] v);
      fix_type r;
      if (v > 64'sd2147483647) begin
         r = FIX_MAX;
      end else if (v < -64'sd2147483648) begin
         r = FIX_MIN;
      end else begin
         r = $signed(v[31:0]);
      end
      return r;
   endfunction

   function automatic fix_type sadd(input fix_type a, input fix_type b);
      return sat32(64'(a) + 64'(b));
   endfunction

   function automatic fix_type ssub(input fix_type a, input fix_type b);
      return sat32(64'(a) - 64'(b));
   endfunction

   // Q16.16 product, round half up, saturate
   function automatic fix_type qmul(input fix_type a, input fix_type b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      p = p + 64'sd32768;
      return sat32(p >>> 16);
   endfunction

   // halve, round half up
   function automatic fix_type rdiv2(input fix_type v);
      logic signed [32:0] n;
      n = 33'(v) + 33'sd1;
      n = n >>> 1;
      return $signed(n[31:0]);
   endfunction

   // bias v+3 to a positive value, then halve: floor((v+3)/6) = floor(u/3) - 2^31
   function automatic logic [33:0] div6_pre(input fix_type v);
      logic signed [35:0] t;
      t = 36'(v) + 36'sd3 + 36'sd12884901888;
      return t[34:1];
   endfunction

   // estimate of floor(u/3), low by at most one
   function automatic logic [33:0] div6_mul(input logic [33:0] u);
      logic [67:0] p;
      p = 68'(u) * 68'(DIV3_MAGIC);
      return p[67:34];
   endfunction

   // correct the estimate and remove the bias
   function automatic fix_type div6_fix(input logic [33:0] u, input logic [33:0] q0);
      logic [35:0] r;
      logic [33:0] q;
      r = 36'(u) - 36'(q0) * 36'd3;
      q = (r >= 36'd3) ? q0 + 34'd1 : q0;
      return $signed(q[31:0] ^ 32'h80000000);
   endfunction

endpackage

// ===== src/ndi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndi_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ndi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, hold data while disabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/newmark_dof_integrator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newmark_dof_integrator_unit
// Per-DOF Newmark integrator with Lagrange displacement extrapolation, Q16.16.
// ----------------------------------------------------------------------------
// The unit takes one word per clock unless the output is stalled or the word
// must wait for its DOF, and returns one result word per request, in order,
// from an output register behind the last pipeline stage. All state of a DOF
// sits in one row of a single RAM that is read when the word is taken and
// written back from the last of ten pipeline stages; a word for a DOF that is
// still in flight waits until that DOF's row is written back, so words on the
// same DOF never overlap, while words on distinct DOFs run at one per cycle
// when the output is not stalled. After reset the unit clears all 1024 rows
// of the state RAM before the first word is taken; register writes are taken
// at any time but must only be made while the unit is idle.
module newmark_dof_integrator_unit
   import ndi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // dof_index, delta_u, iter_count, load_disp, load_vel, load_acc, zero pad
   input  logic [159:0] req_tdata,
   // req_type
   input  logic [2:0]   req_tuser,
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_index, out_disp, out_vel, out_acc, zero pad
   output logic [111:0] rsp_tdata,
   // register write port
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam int NSTG = 10;

   // configuration registers
   fix_type     vel_gain_ff, acc_gain_ff;
   fix_type     pvk_ff, pva_ff, pak_ff, pav_ff;
   logic [1:0]  poly_order_ff;
   logic [16:0] inv_max_iter_ff;

   // pipeline
   pipe_type pipe_ff [1:NSTG];
   pipe_type pipe_in [1:NSTG];
   logic     vld_ff  [1:NSTG];

   // output register
   logic             rsp_vld_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   fix_type          rsp_disp_ff, rsp_vel_ff, rsp_acc_ff;

   // clearing pass
   logic              clr_active_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   logic             adv;
   logic             hazard;
   logic             accept;
   logic [IDX_W-1:0] req_idx;
   logic [ROW_W-1:0] rd_data;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ROW_W-1:0] wr_data;
   row_type          nrow;
   logic             in_range;
   logic [32:0]      xprod;
   logic signed [34:0] acc_sum;
   fix_type          inc_td, inc_tv, inc_ta;

   assign req_idx = req_tdata[9:0];
   assign adv     = !rsp_vld_ff || rsp_tready;
   assign req_tready = !clr_active_ff && adv && !hazard;
   assign accept  = req_tvalid && req_tready;

   // hold back a word whose DOF is still in flight
   always_comb begin
      hazard = 1'b0;
      for (int k = 1; k <= NSTG; k++) begin
         if (vld_ff[k] && pipe_ff[k].idx == req_idx) begin
            hazard = 1'b1;
         end
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vel_gain_ff     <= '0;
         acc_gain_ff     <= '0;
         pvk_ff          <= -ONE_Q;
         pva_ff          <= '0;
         pak_ff          <= -ONE_Q;
         pav_ff          <= '0;
         poly_order_ff   <= POLY_QUAD;
         inv_max_iter_ff <= 17'h10000;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_VEL_GAIN:      vel_gain_ff     <= $signed(csr_wdata);
            CSR_ACC_GAIN:      acc_gain_ff     <= $signed(csr_wdata);
            CSR_PRED_VEL_KEEP: pvk_ff          <= $signed(csr_wdata);
            CSR_PRED_VEL_ACC:  pva_ff          <= $signed(csr_wdata);
            CSR_PRED_ACC_KEEP: pak_ff          <= $signed(csr_wdata);
            CSR_PRED_ACC_VEL:  pav_ff          <= $signed(csr_wdata);
            CSR_POLY_ORDER:    poly_order_ff   <= csr_wdata[1:0];
            CSR_INV_MAX_ITER:  inv_max_iter_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // stage logic
   always_comb begin
      // take the word
      pipe_in[1]      = '0;
      pipe_in[1].typ  = req_tuser;
      pipe_in[1].idx  = req_idx;
      pipe_in[1].du   = $signed(req_tdata[41:10]);
      pipe_in[1].iter = req_tdata[57:42];
      pipe_in[1].ld   = $signed(req_tdata[89:58]);
      pipe_in[1].lv   = $signed(req_tdata[121:90]);
      pipe_in[1].la   = $signed(req_tdata[153:122]);

      // capture the row, form the interpolation point
      pipe_in[2]     = pipe_ff[1];
      pipe_in[2].row = row_type'(rd_data);
      xprod = 33'(pipe_ff[1].iter) * 33'(inv_max_iter_ff);
      pipe_in[2].x = (xprod > 33'd2147483647) ? FIX_MAX : $signed(xprod[31:0]);

      // shifted points and the new displacement
      pipe_in[3]      = pipe_ff[2];
      pipe_in[3].xm1  = ssub(pipe_ff[2].x, ONE_Q);
      pipe_in[3].xp1  = sadd(pipe_ff[2].x, ONE_Q);
      pipe_in[3].xp2  = sadd(pipe_ff[2].x, TWO_Q);
      pipe_in[3].unew = sadd(pipe_ff[2].row.td, pipe_ff[2].du);

      // first product layer, linear terms and predictor products
      pipe_in[4]     = pipe_ff[3];
      pipe_in[4].pa  = qmul(pipe_ff[3].x,   pipe_ff[3].xp1);
      pipe_in[4].pb  = qmul(pipe_ff[3].xm1, pipe_ff[3].xp1);
      pipe_in[4].pc  = qmul(pipe_ff[3].xm1, pipe_ff[3].x);
      pipe_in[4].o1a = qmul(pipe_ff[3].x,   pipe_ff[3].unew);
      pipe_in[4].o1b = qmul(pipe_ff[3].xm1, pipe_ff[3].row.sd);
      pipe_in[4].sva = qmul(pvk_ff, pipe_ff[3].row.tv);
      pipe_in[4].svb = qmul(pva_ff, pipe_ff[3].row.ta);
      pipe_in[4].saa = qmul(pak_ff, pipe_ff[3].row.ta);
      pipe_in[4].sab = qmul(pav_ff, pipe_ff[3].row.tv);

      // second product layer, quadratic weights, predictor sums
      pipe_in[5]     = pipe_ff[4];
      pipe_in[5].qa  = qmul(pipe_ff[4].pa, pipe_ff[4].xp2);
      pipe_in[5].qb  = qmul(pipe_ff[4].pb, pipe_ff[4].xp2);
      pipe_in[5].qc  = qmul(pipe_ff[4].pc, pipe_ff[4].xp2);
      pipe_in[5].qd  = qmul(pipe_ff[4].pc, pipe_ff[4].xp1);
      pipe_in[5].w2a = rdiv2(pipe_ff[4].pa);
      pipe_in[5].w2c = rdiv2(pipe_ff[4].pc);
      pipe_in[5].nv  = sadd(pipe_ff[4].sva, pipe_ff[4].svb);
      pipe_in[5].na  = sadd(pipe_ff[4].saa, pipe_ff[4].sab);

      // divide by six (estimate), cubic halves, quadratic terms
      pipe_in[6]     = pipe_ff[5];
      pipe_in[6].ua  = div6_pre(pipe_ff[5].qa);
      pipe_in[6].ud  = div6_pre(pipe_ff[5].qd);
      pipe_in[6].q0a = div6_mul(pipe_in[6].ua);
      pipe_in[6].q0d = div6_mul(pipe_in[6].ud);
      pipe_in[6].w3b = rdiv2(pipe_ff[5].qb);
      pipe_in[6].w3c = rdiv2(pipe_ff[5].qc);
      pipe_in[6].t2a = qmul(pipe_ff[5].w2a, pipe_ff[5].unew);
      pipe_in[6].t2b = qmul(pipe_ff[5].pb,  pipe_ff[5].row.sd);
      pipe_in[6].t2c = qmul(pipe_ff[5].w2c, pipe_ff[5].row.od);

      // divide by six (correction)
      pipe_in[7]     = pipe_ff[6];
      pipe_in[7].w3a = div6_fix(pipe_ff[6].ua, pipe_ff[6].q0a);
      pipe_in[7].w3d = div6_fix(pipe_ff[6].ud, pipe_ff[6].q0d);

      // cubic terms
      pipe_in[8]     = pipe_ff[7];
      pipe_in[8].t3a = qmul(pipe_ff[7].w3a, pipe_ff[7].unew);
      pipe_in[8].t3b = qmul(pipe_ff[7].w3b, pipe_ff[7].row.sd);
      pipe_in[8].t3c = qmul(pipe_ff[7].w3c, pipe_ff[7].row.od);
      pipe_in[8].t3d = qmul(pipe_ff[7].w3d, pipe_ff[7].row.oo);

      // sum the weighted terms into the increment, or pass delta_u for a commit
      pipe_in[9] = pipe_ff[8];
      case (poly_order_ff)
         POLY_LIN: begin
            acc_sum = -35'(pipe_ff[8].row.td) + 35'(pipe_ff[8].o1a)
                      - 35'(pipe_ff[8].o1b);
         end
         POLY_QUAD: begin
            acc_sum = -35'(pipe_ff[8].row.td) + 35'(pipe_ff[8].t2a)
                      - 35'(pipe_ff[8].t2b) + 35'(pipe_ff[8].t2c);
         end
         POLY_CUBIC: begin
            acc_sum = -35'(pipe_ff[8].row.td) + 35'(pipe_ff[8].t3a)
                      - 35'(pipe_ff[8].t3b) + 35'(pipe_ff[8].t3c)
                      - 35'(pipe_ff[8].t3d);
         end
         default: acc_sum = '0;
      endcase
      pipe_in[9].s = (pipe_ff[8].typ == REQ_COMMIT) ? pipe_ff[8].du
                                                    : sat32(64'(acc_sum));

      // gain products
      pipe_in[10]     = pipe_ff[9];
      pipe_in[10].vgs = qmul(vel_gain_ff, pipe_ff[9].s);
      pipe_in[10].ags = qmul(acc_gain_ff, pipe_ff[9].s);
   end

   // build the new row of the last stage
   always_comb begin
      nrow     = pipe_ff[NSTG].row;
      in_range = int'(pipe_ff[NSTG].idx) < NUM_DOFS;
      inc_td   = sadd(pipe_ff[NSTG].row.td, pipe_ff[NSTG].s);
      inc_tv   = sadd(pipe_ff[NSTG].row.tv, pipe_ff[NSTG].vgs);
      inc_ta   = sadd(pipe_ff[NSTG].row.ta, pipe_ff[NSTG].ags);
      case (pipe_ff[NSTG].typ)
         REQ_LOAD: begin
            nrow.td = pipe_ff[NSTG].ld;
            nrow.sd = pipe_ff[NSTG].ld;
            nrow.od = pipe_ff[NSTG].ld;
            nrow.tv = pipe_ff[NSTG].lv;
            nrow.ta = pipe_ff[NSTG].la;
         end
         REQ_STEP: begin
            nrow.oo = pipe_ff[NSTG].row.od;
            nrow.od = pipe_ff[NSTG].row.sd;
            nrow.sd = pipe_ff[NSTG].row.td;
            nrow.sv = pipe_ff[NSTG].row.tv;
            nrow.sa = pipe_ff[NSTG].row.ta;
            nrow.tv = pipe_ff[NSTG].nv;
            nrow.ta = pipe_ff[NSTG].na;
         end
         REQ_UPDATE: begin
            if (poly_order_ff != POLY_NONE) begin
               nrow.td = inc_td;
               nrow.tv = inc_tv;
               nrow.ta = inc_ta;
            end
         end
         REQ_REVERT: begin
            nrow.td = pipe_ff[NSTG].row.sd;
            nrow.tv = pipe_ff[NSTG].row.sv;
            nrow.ta = pipe_ff[NSTG].row.sa;
            nrow.sd = pipe_ff[NSTG].row.od;
            nrow.od = pipe_ff[NSTG].row.oo;
         end
         REQ_COMMIT: begin
            nrow.td = inc_td;
            nrow.tv = inc_tv;
            nrow.ta = inc_ta;
         end
         default: ;
      endcase
   end

   // state RAM: clear after reset, else write back the last stage
   assign wr_en   = clr_active_ff || (adv && vld_ff[NSTG] && in_range);
   assign wr_addr = clr_active_ff ? clr_cnt_ff : ADDR_W'(pipe_ff[NSTG].idx);
   assign wr_data = clr_active_ff ? '0 : ROW_W'(nrow);

   ndi_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_DOFS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (adv),
      .rd_addr (ADDR_W'(req_idx)),
      .rd_data (rd_data)
   );

   // clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         if (int'(clr_cnt_ff) == NUM_DOFS - 1) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NSTG; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= accept;
         for (int k = 2; k <= NSTG; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_vld_ff <= vld_ff[NSTG];
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 1; k <= NSTG; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
         rsp_idx_ff  <= pipe_ff[NSTG].idx;
         rsp_disp_ff <= in_range ? nrow.td : '0;
         rsp_vel_ff  <= in_range ? nrow.tv : '0;
         rsp_acc_ff  <= in_range ? nrow.ta : '0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'b0, rsp_acc_ff, rsp_vel_ff, rsp_disp_ff, rsp_idx_ff};

endmodule
